// ===== hdl/vbwu_pkg.sv =====
// ----------------------------------------------------------------------------
// vbwu_pkg
// Shared constants and types for the brush weight update pipeline.
// ----------------------------------------------------------------------------
package vbwu_pkg;
	localparam int LAYER_COUNT = 4;
	localparam logic [15:0] ONE_Q15 = 16'd32768;
	localparam logic [15:0] A_MIN = 16'd3;
	localparam logic [15:0] SNAP = 16'd32;

	// isqrt: 64-bit radicand, 32-bit root, 1 root bit (2 radicand bits) per stage
	localparam int SQ_STAGES = 32;
	// divider: 17 quotient bits, 1 per stage
	localparam int DV_STAGES = 17;

	localparam logic [2:0] REG_CX = 3'd0;
	localparam logic [2:0] REG_CY = 3'd1;
	localparam logic [2:0] REG_CZ = 3'd2;
	localparam logic [2:0] REG_RAD = 3'd3;
	localparam logic [2:0] REG_STR = 3'd4;
	localparam logic [2:0] REG_LAYER = 3'd5;
	localparam logic [2:0] REG_ERASE = 3'd6;

	typedef logic [15:0] wt_t;
	typedef wt_t [LAYER_COUNT-1:0] wvec_t;

	// per-item control that travels through the pipe
	typedef struct packed {
		wvec_t w;
		logic far;
		logic [30:0] r;
		logic [15:0] str;
		logic [2:0] layer;
		logic erase;
	} ctl_t;
endpackage

// ===== hdl/vertex_brush_weight_update_top.sv =====
// ----------------------------------------------------------------------------
// vertex_brush_weight_update_top
// Smoothstep falloff weight paint dab applied to one vertex per item.
// ----------------------------------------------------------------------------
// Pipeline: s1 to s3, the isqrt stages, s4, the divider stages, s5 to s8, output register.
// Throughput: one item per cycle; the pipeline of isqrt and divide stages
// advances as a whole on a single enable, held when the output stalls.
// Reset: arst_n clears valid bits and config registers (all zero).
module vertex_brush_weight_update_top
	import vbwu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [15:0] weight_0,
	input  logic [15:0] weight_1,
	input  logic [15:0] weight_2,
	input  logic [15:0] weight_3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] new_weight_0,
	output logic [15:0] new_weight_1,
	output logic [15:0] new_weight_2,
	output logic [15:0] new_weight_3,
	output logic        changed
);
	logic signed [31:0] cx_q, cy_q, cz_q;
	logic [30:0] rad_q;
	logic [15:0] str_q;
	logic [2:0] layer_q;
	logic erase_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cx_q <= '0; cy_q <= '0; cz_q <= '0; rad_q <= '0;
			str_q <= '0; layer_q <= '0; erase_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CX: cx_q <= cfg_data;
				REG_CY: cy_q <= cfg_data;
				REG_CZ: cz_q <= cfg_data;
				REG_RAD: rad_q <= cfg_data[30:0];
				REG_STR: str_q <= cfg_data[15:0];
				REG_LAYER: layer_q <= cfg_data[2:0];
				REG_ERASE: erase_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// whole pipe moves when the output slot is free or empty
	logic adv;
	assign adv = !out_valid || out_ready;
	assign in_ready = adv;

	// ---- s1: offsets, saturate weights
	logic v_s1;
	logic [32:0] ax_s1, ay_s1, az_s1;
	ctl_t c_s1;
	wvec_t win;
	logic [15:0] wraw [LAYER_COUNT];
	assign wraw[0] = weight_0;
	assign wraw[1] = weight_1;
	assign wraw[2] = weight_2;
	assign wraw[3] = weight_3;
	always_comb begin
		for (int k = 0; k < LAYER_COUNT; k++)
			win[k] = (wraw[k] > ONE_Q15) ? ONE_Q15 : wraw[k];
	end
	function automatic logic [32:0] absd(logic signed [31:0] a, logic signed [31:0] b);
		logic signed [32:0] d;
		d = 33'(a) - 33'(b);
		return d[32] ? 33'(-d) : 33'(d);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (adv) v_s1 <= in_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			ax_s1 <= absd(pos_x, cx_q);
			ay_s1 <= absd(pos_y, cy_q);
			az_s1 <= absd(pos_z, cz_q);
			c_s1.w <= win;
			c_s1.far <= 1'b0;
			c_s1.r <= rad_q;
			c_s1.str <= str_q;
			c_s1.layer <= layer_q;
			c_s1.erase <= erase_q;
		end
	end

	// ---- s2: far test, squares (offsets below r fit 31 bits)
	logic v_s2;
	logic [61:0] sx_s2, sy_s2, sz_s2;
	ctl_t c_s2;
	logic far1;
	ctl_t c1n;
	assign far1 = (c_s1.r == '0) || (ax_s1 >= 33'(c_s1.r)) || (ay_s1 >= 33'(c_s1.r))
		|| (az_s1 >= 33'(c_s1.r));
	always_comb begin
		c1n = c_s1;
		c1n.far = far1;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (adv) v_s2 <= v_s1;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sx_s2 <= 62'(ax_s1[30:0]) * 62'(ax_s1[30:0]);
			sy_s2 <= 62'(ay_s1[30:0]) * 62'(ay_s1[30:0]);
			sz_s2 <= 62'(az_s1[30:0]) * 62'(az_s1[30:0]);
			c_s2 <= c1n;
		end
	end

	// ---- s3: sum of squares
	logic v_s3;
	logic [63:0] sum_s3;
	ctl_t c_s3;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s3 <= 1'b0;
		else if (adv) v_s3 <= v_s2;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s3 <= 64'(sx_s2) + 64'(sy_s2) + 64'(sz_s2);
			c_s3 <= c_s2;
		end
	end

	// ---- isqrt: restoring, two radicand bits per stage
	logic sq_v [SQ_STAGES+1];
	logic [63:0] sq_rem [SQ_STAGES+1];
	logic [31:0] sq_root [SQ_STAGES+1];
	logic [63:0] sq_rad [SQ_STAGES+1];
	ctl_t sq_c [SQ_STAGES+1];
	assign sq_v[0] = v_s3;
	assign sq_rem[0] = '0;
	assign sq_root[0] = '0;
	assign sq_rad[0] = sum_s3;
	assign sq_c[0] = c_s3;
	for (genvar i = 0; i < SQ_STAGES; i++) begin : g_sq
		logic [65:0] trial, remx;
		assign remx = {sq_rem[i], sq_rad[i][63:62]};
		assign trial = {32'd0, sq_root[i], 2'b01};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v[i+1] <= 1'b0;
			else if (adv) sq_v[i+1] <= sq_v[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_rad[i+1] <= {sq_rad[i][61:0], 2'b00};
				sq_c[i+1] <= sq_c[i];
				if (remx >= trial) begin
					sq_rem[i+1] <= 64'(remx - trial);
					sq_root[i+1] <= {sq_root[i][30:0], 1'b1};
				end else begin
					sq_rem[i+1] <= remx[63:0];
					sq_root[i+1] <= {sq_root[i][30:0], 1'b0};
				end
			end
		end
	end

	// ---- s4: d vs r, numerator (r-d)<<16
	logic v_s4;
	logic [46:0] num_s4;
	ctl_t c_s4;
	logic [31:0] dq;
	logic d_far;
	logic [30:0] rd;
	ctl_t c3n;
	assign dq = sq_root[SQ_STAGES];
	assign d_far = sq_c[SQ_STAGES].far || (dq >= 32'(sq_c[SQ_STAGES].r));
	assign rd = sq_c[SQ_STAGES].r - dq[30:0];
	always_comb begin
		c3n = sq_c[SQ_STAGES];
		c3n.far = d_far;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s4 <= 1'b0;
		else if (adv) v_s4 <= sq_v[SQ_STAGES];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s4 <= c3n;
			num_s4 <= d_far ? 47'd0 : {rd, 16'd0};
		end
	end

	// ---- divider: quotient t < 2^17, one bit per stage
	logic dv_v [DV_STAGES+1];
	logic [31:0] dv_rem [DV_STAGES+1];
	logic [46:0] dv_num [DV_STAGES+1];
	logic [16:0] dv_q [DV_STAGES+1];
	ctl_t dv_c [DV_STAGES+1];
	assign dv_v[0] = v_s4;
	// top bits (r-d)>>1 are already below r, so only 17 quotient bits remain
	assign dv_rem[0] = 32'(num_s4[46:17]);
	assign dv_num[0] = num_s4;
	assign dv_q[0] = '0;
	assign dv_c[0] = c_s4;
	for (genvar i = 0; i < DV_STAGES; i++) begin : g_dv
		logic [31:0] rx;
		assign rx = {dv_rem[i][30:0], dv_num[i][DV_STAGES-1-i]};
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v[i+1] <= 1'b0;
			else if (adv) dv_v[i+1] <= dv_v[i];
		end
		always_ff @(posedge clk) begin
			if (adv) begin
				dv_num[i+1] <= dv_num[i];
				dv_c[i+1] <= dv_c[i];
				if (rx >= 32'(dv_c[i].r)) begin
					dv_rem[i+1] <= rx - 32'(dv_c[i].r);
					dv_q[i+1] <= {dv_q[i][15:0], 1'b1};
				end else begin
					dv_rem[i+1] <= rx;
					dv_q[i+1] <= {dv_q[i][15:0], 1'b0};
				end
			end
		end
	end

	// ---- s5: t*t and 3*65536-2t
	logic v_s5;
	logic [33:0] t2_s5;
	logic [18:0] k_s5;
	ctl_t c_s5;
	logic [16:0] tq;
	// far items force t to zero regardless of the divider result
	assign tq = dv_c[DV_STAGES].far ? 17'd0 : dv_q[DV_STAGES];
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s5 <= 1'b0;
		else if (adv) v_s5 <= dv_v[DV_STAGES];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			t2_s5 <= 34'(tq) * 34'(tq);
			k_s5 <= 19'd196608 - {1'b0, tq, 1'b0};
			c_s5 <= dv_c[DV_STAGES];
		end
	end

	// ---- s6: falloff
	logic v_s6;
	logic [15:0] f_s6;
	ctl_t c_s6;
	logic [52:0] fp;
	assign fp = 53'(t2_s5) * 53'(k_s5);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s6 <= 1'b0;
		else if (adv) v_s6 <= v_s5;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			f_s6 <= fp[48:33];
			c_s6 <= c_s5;
		end
	end

	// ---- s7: amount a
	logic v_s7;
	logic [15:0] a_s7;
	ctl_t c_s7;
	logic [31:0] ap;
	assign ap = 32'(c_s6.str) * 32'(f_s6);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s7 <= 1'b0;
		else if (adv) v_s7 <= v_s6;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			a_s7 <= (ap[31:15] > 17'(ONE_Q15)) ? ONE_Q15 : ap[30:15];
			c_s7 <= c_s6;
		end
	end

	// ---- s8: products and decisions
	logic v_s8;
	wvec_t pw_s8, ew_s8;
	ctl_t c_s8;
	logic app_s8;
	logic any0;
	always_comb begin
		any0 = 1'b0;
		for (int k = 0; k < LAYER_COUNT; k++) any0 |= (c_s7.w[k] != '0);
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s8 <= 1'b0;
		else if (adv) v_s8 <= v_s7;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			c_s8 <= c_s7;
			app_s8 <= (a_s7 > A_MIN) && (c_s7.erase ? any0
				: (c_s7.layer < 3'(LAYER_COUNT)));
			for (int k = 0; k < LAYER_COUNT; k++) begin
				logic [31:0] pr;
				if (3'(k) == c_s7.layer)
					pr = 32'(ONE_Q15 - c_s7.w[k]) * 32'(a_s7);
				else
					pr = 32'(c_s7.w[k]) * 32'(ONE_Q15 - a_s7);
				pw_s8[k] <= (3'(k) == c_s7.layer) ? c_s7.w[k] + pr[30:15] : pr[30:15];
				ew_s8[k] <= (17'(c_s7.w[k]) <= 17'(a_s7) + 17'(SNAP)) ? 16'd0
					: c_s7.w[k] - a_s7;
			end
		end
	end

	// ---- output register
	wvec_t ow_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (adv) out_valid <= v_s8;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			changed <= app_s8;
			ow_q <= !app_s8 ? c_s8.w : (c_s8.erase ? ew_s8 : pw_s8);
		end
	end
	assign new_weight_0 = ow_q[0];
	assign new_weight_1 = ow_q[1];
	assign new_weight_2 = ow_q[2];
	assign new_weight_3 = ow_q[3];

`ifndef NO_ASSERTIONS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(new_weight_0) && $stable(changed))
		else $error("output changed under stall");
	a_unchanged_pass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !changed |-> new_weight_0 <= ONE_Q15)
		else $error("pass-through weight out of range");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("pipe stalled while output empty");
`endif
endmodule

// ===== test/vertex_brush_weight_update_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_brush_weight_update_checker
// Watches both item channels, predicts the updated weights of every accepted
// vertex with its own copy of the brush registers, and compares the results
// in order.
// ----------------------------------------------------------------------------
module vertex_brush_weight_update_checker
	import vbwu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic [15:0] weight_0,
	input  logic [15:0] weight_1,
	input  logic [15:0] weight_2,
	input  logic [15:0] weight_3,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [15:0] new_weight_0,
	input  logic [15:0] new_weight_1,
	input  logic [15:0] new_weight_2,
	input  logic [15:0] new_weight_3,
	input  logic        changed,
	output int          fail_count,
	output int          pending
);
	typedef struct packed {
		wvec_t w;
		logic chg;
	} dab_t;

	logic signed [31:0] bc_x, bc_y, bc_z;
	logic [30:0] b_rad;
	logic [15:0] b_str;
	logic [2:0] b_layer;
	logic b_erase;
	dab_t dab_q[$];

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] res, bit_v;
		res = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > v) bit_v >>= 2;
		while (bit_v != 0) begin
			if (v >= res + bit_v) begin
				v -= res + bit_v;
				res = (res >> 1) + bit_v;
			end else begin
				res >>= 1;
			end
			bit_v >>= 2;
		end
		return res;
	endfunction

	function automatic logic [63:0] offset(input logic signed [31:0] p,
			input logic signed [31:0] c);
		longint d;
		d = longint'(p) - longint'(c);
		return d < 0 ? 64'(-d) : 64'(d);
	endfunction

	function automatic dab_t brush_dab(input logic signed [31:0] px, py, pz,
			input wvec_t win);
		dab_t o;
		logic [63:0] ax, ay, az, r, d, t, f, a;
		logic any;
		for (int k = 0; k < LAYER_COUNT; k++)
			o.w[k] = win[k] > ONE_Q15 ? ONE_Q15 : win[k];
		o.chg = 0;
		ax = offset(px, bc_x);
		ay = offset(py, bc_y);
		az = offset(pz, bc_z);
		r = 64'(b_rad);
		f = 0;
		if (r != 0 && ax < r && ay < r && az < r) begin
			d = root64(ax * ax + ay * ay + az * az);
			if (d < r) begin
				t = ((r - d) << 16) / r;
				f = (t * t * (3 * 65536 - 2 * t)) >> 33;
			end
		end
		a = (64'(b_str) * f) >> 15;
		if (a > ONE_Q15) a = ONE_Q15;
		if (a > A_MIN) begin
			if (b_erase) begin
				any = 0;
				for (int k = 0; k < LAYER_COUNT; k++) if (o.w[k] != 0) any = 1;
				if (any) begin
					for (int k = 0; k < LAYER_COUNT; k++)
						o.w[k] = (o.w[k] <= a + SNAP) ? 16'd0 : 16'(o.w[k] - a);
					o.chg = 1;
				end
			end else if (b_layer < LAYER_COUNT) begin
				for (int k = 0; k < LAYER_COUNT; k++) begin
					if (k == b_layer)
						o.w[k] = 16'(o.w[k] + (((ONE_Q15 - o.w[k]) * a) >> 15));
					else
						o.w[k] = 16'((64'(o.w[k]) * (ONE_Q15 - a)) >> 15);
				end
				o.chg = 1;
			end
		end
		return o;
	endfunction

	assign pending = dab_q.size();

	always @(posedge clk or negedge arst_n) begin
		dab_t e, got;
		if (!arst_n) begin
			bc_x <= 0; bc_y <= 0; bc_z <= 0;
			b_rad <= 0; b_str <= 0; b_layer <= 0; b_erase <= 0;
			fail_count <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_CX: bc_x <= cfg_data;
					REG_CY: bc_y <= cfg_data;
					REG_CZ: bc_z <= cfg_data;
					REG_RAD: b_rad <= cfg_data[30:0];
					REG_STR: b_str <= cfg_data[15:0];
					REG_LAYER: b_layer <= cfg_data[2:0];
					REG_ERASE: b_erase <= cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				dab_q = {dab_q, brush_dab(pos_x, pos_y, pos_z,
					{weight_3, weight_2, weight_1, weight_0})};
			if (out_valid && out_ready) begin
				got.w = {new_weight_3, new_weight_2, new_weight_1, new_weight_0};
				got.chg = changed;
				if (dab_q.size() == 0) begin
					if (fail_count < 10) $display("unexpected item %h", got);
					fail_count <= fail_count + 1;
				end else begin
					e = dab_q.pop_front();
					if (e !== got) begin
						if (fail_count < 10)
							$display("mismatch: exp w=%h chg=%b got w=%h chg=%b",
								e.w, e.chg, got.w, got.chg);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// ===== test/vertex_brush_weight_update_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_brush_weight_update_top_tb
// Drives vertices through several brush settings with random gaps and output
// stalls; the checker predicts and compares every updated item.
// ----------------------------------------------------------------------------
module vertex_brush_weight_update_top_tb;
	import vbwu_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [2:0] cfg_index = 0;
	logic [31:0] cfg_data = 0;
	logic in_valid = 0, in_ready, out_valid, out_ready = 0;
	logic signed [31:0] pos_x = 0, pos_y = 0, pos_z = 0;
	logic [15:0] weight_0 = 0, weight_1 = 0, weight_2 = 0, weight_3 = 0;
	logic [15:0] new_weight_0, new_weight_1, new_weight_2, new_weight_3;
	logic changed;
	int fail_count, pending;
	bit feeding = 0;

	logic signed [31:0] cx, cy, cz;
	logic [30:0] rad;

	always #5 clk = ~clk;

	vertex_brush_weight_update_top u_dut (.*);
	vertex_brush_weight_update_checker u_chk (.*);

	function automatic int gap_len();
		return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) :
			$urandom_range(0, 2);
	endfunction

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_brush(input logic [31:0] x, y, z, r, s, l, e);
		cx = x; cy = y; cz = z; rad = r[30:0];
		reg_write(REG_CX, x); reg_write(REG_CY, y); reg_write(REG_CZ, z);
		reg_write(REG_RAD, r); reg_write(REG_STR, s);
		reg_write(REG_LAYER, l); reg_write(REG_ERASE, e);
	endtask

	function automatic logic [15:0] rand_wt();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return ONE_Q15;
			2: return 16'($urandom);
			default: return 16'($urandom_range(0, 32768));
		endcase
	endfunction

	// near axis offset mostly inside the radius
	function automatic logic [31:0] near_coord(input logic signed [31:0] c);
		longint off;
		off = (rad == 0) ? longint'($urandom_range(0, 1000)) :
			longint'($urandom_range(0, 32'(rad))) * 3 / 5;
		if ($urandom_range(0, 1)) off = -off;
		return 32'(longint'(c) + off);
	endfunction

	// valid stays high into the next item when the gap is zero
	task automatic send(input logic [31:0] x, y, z, input logic [15:0] a, b, c, d);
		int g;
		if (!in_valid) @(negedge clk);
		in_valid <= 1;
		pos_x <= x; pos_y <= y; pos_z <= z;
		weight_0 <= a; weight_1 <= b; weight_2 <= c; weight_3 <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		g = gap_len();
		@(negedge clk);
		if (g != 0) begin
			in_valid <= 0;
			repeat (g) @(negedge clk);
		end
	endtask

	task automatic send_random();
		if ($urandom_range(0, 9) < 8)
			send(near_coord(cx), near_coord(cy), near_coord(cz),
				rand_wt(), rand_wt(), rand_wt(), rand_wt());
		else
			send($urandom, $urandom, $urandom, rand_wt(), rand_wt(), rand_wt(),
				rand_wt());
	endtask

	task automatic drain();
		int n;
		n = 0;
		if (in_valid) in_valid <= 0;
		while (pending != 0 && n < 200000) begin
			@(posedge clk);
			n++;
		end
		repeat (60) @(posedge clk);
	endtask

	always @(negedge clk) begin
		if (feeding && $urandom_range(0, 3) == 0)
			out_ready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
		else if (!feeding)
			out_ready <= 1;
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		feeding = 1;
		rad = 0; cx = 0; cy = 0; cz = 0;
		// zero radius from reset
		send(0, 0, 0, 16'd100, 16'd200, 16'd300, 16'd400);
		drain();
		set_brush(0, 0, 0, 32'h0004_0000, 32'h8000, 1, 0);
		send(0, 0, 0, 0, 0, 0, 0);
		send(0, 0, 0, 16'hFFFF, 16'h8000, 16'h4000, 16'h0);
		send(32'h0001_0000, 0, 0, 16'd1000, 16'd2000, 16'd3000, 16'd4000);
		send(32'h0004_0000, 0, 0, 16'd1000, 16'd2000, 16'd3000, 16'd4000);
		send(32'h0003_ffff, 0, 0, 16'd1000, 16'd2000, 16'd3000, 16'd4000);
		send(32'h0003_0000, 32'h0003_0000, 0, 16'd1000, 16'd1, 16'd3, 16'd4000);
		send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 1, 2, 3, 4);
		drain();
		set_brush(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
			32'hFFFF, 7, 0);
		send(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'd5, 16'd6, 16'd7, 16'd8);
		send(32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000, 16'd5, 16'd6, 16'd7, 16'd8);
		drain();
		set_brush(0, 0, 0, 32'h0010_0000, 32'h4000, 4, 1);
		send(0, 0, 0, 0, 0, 0, 0);
		send(0, 0, 0, 0, 0, 0, 16'd1);
		send(0, 0, 0, 16'd16400, 16'd16416, 16'd16417, 16'hFFFF);
		send(32'h000f_0000, 0, 0, 16'd100, 16'd200, 16'd300, 16'd400);
		drain();
		set_brush(0, 0, 0, 32'h0010_0000, 32'd1, 3, 0);
		send(0, 0, 0, 16'd100, 16'd200, 16'd300, 16'd400);
		drain();
		for (int ph = 0; ph < 10; ph++) begin
			set_brush($urandom, $urandom, $urandom,
				(ph % 3 == 0) ? 32'($urandom) : 32'($urandom_range(1, 32'h0040_0000)),
				(ph == 4) ? 32'hFFFF : 32'($urandom_range(0, 65535)),
				$urandom_range(0, 7) & ((ph % 2) ? 3'd3 : 3'd7), $urandom_range(0, 1));
			for (int i = 0; i < 125; i++) send_random();
			drain();
		end
		feeding = 0;
		drain();
		if (fail_count == 0 && pending == 0)
			$display("vertex_brush_weight_update_top verification clean");
		else
			$display("vertex_brush_weight_update_top verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("vertex_brush_weight_update_top verification failed");
		$finish;
	end
endmodule
